>>> rtl/fifo_queue_with_stats_unit_defines.svh
// assertion macros for the queue unit
// each expects clk and arst_n in the scope where it is used
`ifndef FIFO_QUEUE_WITH_STATS_UNIT_DEFINES_SVH
`define FIFO_QUEUE_WITH_STATS_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

// property checked at every clock edge outside reset
`define FQS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) \
		else $error(msg);

// implication with the consequent in the following cycle
`define FQS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`else

`define FQS_ASSERT(label, prop, msg)
`define FQS_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

>>> rtl/fqs_pkg.sv
`default_nettype none

package fqs_pkg;

	// default number of queue entries
	localparam int DEPTH_DEF = 16;

	// field widths
	localparam int WORD_W = 32;
	localparam int OP_W   = 3;
	localparam int ST_W   = 2;

	// operation codes
	typedef enum logic [OP_W-1:0] {
		OP_PUSH    = 3'd0,
		OP_POP     = 3'd1,
		OP_CLEAR   = 3'd2,
		OP_DUMP    = 3'd3,
		OP_MEAN    = 3'd4,
		OP_EVENS   = 3'd5,
		OP_COUNT   = 3'd6,
		OP_REVERSE = 3'd7
	} op_t;

	// result status codes
	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	// divider status toward the controller
	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

`default_nettype wire

>>> rtl/fqs_in_if.sv
`default_nettype none

// request channel: operation and value
interface fqs_in_if;
	logic                              valid;
	logic                              ready;
	logic [fqs_pkg::OP_W-1:0]          operation;
	logic signed [fqs_pkg::WORD_W-1:0] value;

	modport source (output valid, output operation, output value, input ready);
	modport sink (input valid, input operation, input value, output ready);
endinterface

`default_nettype wire

>>> rtl/fqs_out_if.sv
`default_nettype none

// result channel
interface fqs_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [fqs_pkg::WORD_W-1:0] result_value;
	logic [fqs_pkg::ST_W-1:0]          status;
	logic                              last;

	modport source (output valid, output result_value, output status, output last,
		input ready);
	modport sink (input valid, input result_value, input status, input last,
		output ready);
endinterface

`default_nettype wire

>>> rtl/fqs_ram.sv
`default_nettype none

// entry store: one write port, one read port with registered data
module fqs_ram #(
	parameter int DEPTH = fqs_pkg::DEPTH_DEF,
	parameter int WIDTH = fqs_pkg::WORD_W
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// read port, data holds while no read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

>>> rtl/fqs_div.sv
`default_nettype none

// signed by unsigned divider, one quotient bit per cycle, truncates toward zero
module fqs_div #(
	parameter int NUM_W = 37,
	parameter int DEN_W = 5
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic signed [NUM_W-1:0] num,
	input  wire logic [DEN_W-1:0]        den,
	output fqs_pkg::div_stat_t           stat,
	output logic signed [NUM_W-1:0]      quot
);

	localparam int STEP_W = $clog2(NUM_W + 1);

	logic [NUM_W-1:0]  mag_q;
	logic [DEN_W-1:0]  rem_q;
	logic [DEN_W-1:0]  den_q;
	logic [STEP_W-1:0] step_q;
	logic              neg_q;
	logic              done_q;

	logic [DEN_W:0]    trial;
	logic              fits;
	logic [DEN_W-1:0]  rem_d;

	// restoring step on the next dividend bit
	always_comb begin
		trial = {rem_q, mag_q[NUM_W-1]};
		fits  = trial >= {1'b0, den_q};
		rem_d = fits ? DEN_W'(trial - {1'b0, den_q}) : DEN_W'(trial);
	end

	// iteration control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (step_q == STEP_W'(1));
			if (start) begin
				step_q <= STEP_W'(NUM_W);
			end else if (step_q != '0) begin
				step_q <= step_q - 1'b1;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (start) begin
			neg_q <= num[NUM_W-1];
			mag_q <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
			rem_q <= '0;
			den_q <= den;
		end else if (step_q != '0) begin
			rem_q <= rem_d;
			mag_q <= {mag_q[NUM_W-2:0], fits};
		end
	end

	assign quot      = neg_q ? $signed(-mag_q) : $signed(mag_q);
	assign stat.busy = (step_q != '0);
	assign stat.done = done_q;

endmodule

`default_nettype wire

>>> rtl/fifo_queue_with_stats_unit.sv
`default_nettype none

// Bounded FIFO of signed 32-bit words held in a DEPTH-entry ring RAM with a single
// read port. A request is taken only while the controller is idle; a result may still
// wait in the output register. Push, clear and any request on an empty queue pass from
// the decide state straight back to idle; pop passes through the walk state first.
// Dump, dump reversed, count and dump evens walk the ring one entry per cycle through
// the RAM read port. Mean walks the ring and then runs a bit-serial divider, one
// quotient bit per cycle over the 32 + $clog2(DEPTH+1)-bit sum. A stalled result
// channel holds the walk.
// There is no clearing pass: only entries written by a push are ever read.

`include "fifo_queue_with_stats_unit_defines.svh"

module fifo_queue_with_stats_unit #(
	parameter int DEPTH = fqs_pkg::DEPTH_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	fqs_in_if.sink   in_ch,
	fqs_out_if.source out_ch
);

	localparam int WORD_W = fqs_pkg::WORD_W;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int SUM_W  = WORD_W + CNT_W;

	typedef enum logic [5:0] {
		S_IDLE   = 6'b000001,
		S_DECIDE = 6'b000010,
		S_WALK   = 6'b000100,
		S_DIVGO  = 6'b001000,
		S_DIV    = 6'b010000,
		S_DONE   = 6'b100000
	} state_t;

	state_t                   state_q;
	fqs_pkg::op_t             op_q;
	logic signed [WORD_W-1:0] key_q;
	logic [IDX_W-1:0]         head_q;
	logic [CNT_W-1:0]         cnt_q;
	logic [IDX_W-1:0]         ptr_q;
	logic [CNT_W-1:0]         left_q;
	logic signed [SUM_W-1:0]  acc_q;
	logic                     pend_vld_q;
	logic signed [WORD_W-1:0] pend_q;

	logic                     out_vld_q;
	logic signed [WORD_W-1:0] out_val_q;
	fqs_pkg::status_t         out_st_q;
	logic                     out_last_q;

	logic                     emit_req;
	logic signed [WORD_W-1:0] emit_val;
	fqs_pkg::status_t         emit_st;
	logic                     emit_last;
	logic                     out_free;
	logic                     step_ok;

	logic                     full;
	logic [IDX_W:0]           tsum;
	logic [IDX_W-1:0]         tail_ptr;
	logic [IDX_W-1:0]         start_ptr;
	logic [IDX_W-1:0]         walk_next;

	logic                     ram_we;
	logic                     ram_re;
	logic [IDX_W-1:0]         ram_raddr;
	logic signed [WORD_W-1:0] rd_word;

	logic                     div_start;
	fqs_pkg::div_stat_t       div_stat;
	logic signed [SUM_W-1:0]  div_quot;

	function automatic logic [IDX_W-1:0] ptr_inc(input logic [IDX_W-1:0] p);
		return (p == IDX_W'(DEPTH - 1)) ? '0 : IDX_W'(p + 1'b1);
	endfunction

	function automatic logic [IDX_W-1:0] ptr_dec(input logic [IDX_W-1:0] p);
		return (p == '0) ? IDX_W'(DEPTH - 1) : IDX_W'(p - 1'b1);
	endfunction

	// ring positions
	always_comb begin
		full      = (cnt_q == CNT_W'(DEPTH));
		tsum      = (IDX_W + 1)'(head_q) + (IDX_W + 1)'(cnt_q);
		tail_ptr  = (tsum >= (IDX_W + 1)'(DEPTH)) ? IDX_W'(tsum - (IDX_W + 1)'(DEPTH))
			: IDX_W'(tsum);
		start_ptr = (op_q == fqs_pkg::OP_REVERSE) ? ptr_dec(tail_ptr) : head_q;
		walk_next = (op_q == fqs_pkg::OP_REVERSE) ? ptr_dec(ptr_q) : ptr_inc(ptr_q);
	end

	assign out_free = !out_vld_q || out_ch.ready;
	assign step_ok  = !emit_req || out_free;

	// result selection and ram reads per state
	always_comb begin
		emit_req  = 1'b0;
		emit_val  = '0;
		emit_st   = fqs_pkg::ST_OK;
		emit_last = 1'b1;
		ram_we    = 1'b0;
		ram_re    = 1'b0;
		ram_raddr = walk_next;
		div_start = 1'b0;
		case (state_q)
			S_DECIDE: begin
				ram_raddr = start_ptr;
				case (op_q)
					fqs_pkg::OP_PUSH: begin
						emit_req = 1'b1;
						emit_st  = full ? fqs_pkg::ST_FULL : fqs_pkg::ST_OK;
						ram_we   = !full && out_free;
					end
					fqs_pkg::OP_CLEAR: begin
						emit_req = 1'b1;
					end
					default: begin
						if (cnt_q == '0) begin
							emit_req = 1'b1;
							emit_st  = (op_q == fqs_pkg::OP_COUNT) ? fqs_pkg::ST_OK
								: fqs_pkg::ST_EMPTY;
						end else begin
							ram_re = 1'b1;
						end
					end
				endcase
			end
			S_WALK: begin
				case (op_q)
					fqs_pkg::OP_POP: begin
						emit_req = 1'b1;
						emit_val = rd_word;
					end
					fqs_pkg::OP_DUMP, fqs_pkg::OP_REVERSE: begin
						emit_req  = 1'b1;
						emit_val  = rd_word;
						emit_last = (left_q == CNT_W'(1));
					end
					fqs_pkg::OP_EVENS: begin
						// previous even entry goes out once another one is found
						emit_req  = !rd_word[0] && pend_vld_q;
						emit_val  = pend_q;
						emit_last = 1'b0;
					end
					default: begin
						emit_req = 1'b0;
					end
				endcase
				ram_re = step_ok && (left_q != CNT_W'(1));
			end
			S_DIVGO: begin
				div_start = 1'b1;
			end
			S_DONE: begin
				case (op_q)
					fqs_pkg::OP_MEAN: begin
						emit_req = 1'b1;
						emit_val = div_quot[WORD_W-1:0];
					end
					fqs_pkg::OP_EVENS: begin
						emit_req = pend_vld_q;
						emit_val = pend_q;
					end
					default: begin
						emit_req = 1'b1;
						emit_val = acc_q[WORD_W-1:0];
					end
				endcase
			end
			default: begin
				emit_req = 1'b0;
			end
		endcase
	end

	// sequencer and queue pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			head_q     <= '0;
			cnt_q      <= '0;
			pend_vld_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						state_q <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					if (step_ok) begin
						case (op_q)
							fqs_pkg::OP_PUSH: begin
								if (!full) begin
									cnt_q <= cnt_q + 1'b1;
								end
								state_q <= S_IDLE;
							end
							fqs_pkg::OP_CLEAR: begin
								head_q  <= '0;
								cnt_q   <= '0;
								state_q <= S_IDLE;
							end
							default: begin
								pend_vld_q <= 1'b0;
								state_q    <= (cnt_q == '0) ? S_IDLE : S_WALK;
							end
						endcase
					end
				end
				S_WALK: begin
					if (step_ok) begin
						if (op_q == fqs_pkg::OP_POP) begin
							head_q <= ptr_inc(head_q);
							cnt_q  <= cnt_q - 1'b1;
						end
						if (op_q == fqs_pkg::OP_EVENS && !rd_word[0]) begin
							pend_vld_q <= 1'b1;
						end
						if (left_q == CNT_W'(1)) begin
							case (op_q)
								fqs_pkg::OP_MEAN: state_q <= S_DIVGO;
								fqs_pkg::OP_COUNT, fqs_pkg::OP_EVENS: state_q <= S_DONE;
								default: state_q <= S_IDLE;
							endcase
						end
					end
				end
				S_DIVGO: begin
					state_q <= S_DIV;
				end
				S_DIV: begin
					if (div_stat.done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (step_ok) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// request latch, walk position and accumulators
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_ch.valid) begin
			op_q  <= fqs_pkg::op_t'(in_ch.operation);
			key_q <= in_ch.value;
		end
		if (state_q == S_DECIDE) begin
			ptr_q  <= start_ptr;
			left_q <= (op_q == fqs_pkg::OP_POP) ? CNT_W'(1) : cnt_q;
			acc_q  <= '0;
		end
		if (state_q == S_WALK && step_ok) begin
			ptr_q  <= walk_next;
			left_q <= left_q - 1'b1;
			case (op_q)
				fqs_pkg::OP_MEAN: acc_q <= acc_q + SUM_W'(rd_word);
				fqs_pkg::OP_COUNT: acc_q <= acc_q + SUM_W'(rd_word == key_q);
				fqs_pkg::OP_EVENS: begin
					if (!rd_word[0]) begin
						pend_q <= rd_word;
					end
				end
				default: acc_q <= acc_q;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (emit_req && out_free) begin
			out_vld_q <= 1'b1;
		end else if (out_ch.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_req && out_free) begin
			out_val_q  <= emit_val;
			out_st_q   <= emit_st;
			out_last_q <= emit_last;
		end
	end

	assign in_ch.ready         = (state_q == S_IDLE);
	assign out_ch.valid        = out_vld_q;
	assign out_ch.result_value = out_val_q;
	assign out_ch.status       = out_st_q;
	assign out_ch.last         = out_last_q;

	// entry store
	fqs_ram #(
		.DEPTH (DEPTH),
		.WIDTH (WORD_W)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (tail_ptr),
		.wdata (key_q),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (rd_word)
	);

	// mean divider
	fqs_div #(
		.NUM_W (SUM_W),
		.DEN_W (CNT_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (acc_q),
		.den    (cnt_q),
		.stat   (div_stat),
		.quot   (div_quot)
	);

	// checks
	`FQS_ASSERT_NEXT(a_accept, in_ch.valid && in_ch.ready, state_q == S_DECIDE, "no decode")
	`FQS_ASSERT(a_div_busy, (div_stat.busy || div_stat.done) |-> (state_q == S_DIV), "stray div")
	`FQS_ASSERT(a_cnt_range, cnt_q <= CNT_W'(DEPTH), "entry count beyond depth")
	`FQS_ASSERT(a_walk_left, (state_q == S_WALK) |-> (left_q != '0), "walk with nothing left")

endmodule

`default_nettype wire
